### design/assert_macros.svh
// Assertion macros used by the statistics engine.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### design/fwbs_pkg.sv
// Package: shared types and constants of the flow window statistics block.
`timescale 1ns / 1ps
package fwbs_pkg;
  localparam int unsigned NUM_STATS = 14;
  localparam logic [3:0] LAST_IDX = 4'd13;
  localparam logic [19:0] NS_PER_MS = 20'd1000000;

  localparam logic [2:0] REG_BYTE_EN = 3'd0;
  localparam logic [2:0] REG_GAP_EN = 3'd1;
  localparam logic [2:0] REG_BURST_EN = 3'd2;
  localparam logic [2:0] REG_THRESH = 3'd3;
  localparam logic [2:0] REG_SHORT = 3'd4;
  localparam logic [2:0] REG_LONG = 3'd5;

  localparam logic FUNC_PKT = 1'b0;
  localparam logic FUNC_CLOSE = 1'b1;

  typedef struct packed {
    logic        func;
    logic [62:0] arrival_time;
    logic [15:0] pkt_len;
  } req_t;

  typedef struct packed {
    logic        byte_en;
    logic        gap_en;
    logic        burst_en;
    logic [31:0] thresh;
    logic [51:0] short_ns;
    logic [51:0] long_ns;
  } cfg_t;
endpackage

### design/fwbs_in_if.sv
// Interfaces: request channel and result channel.
`timescale 1ns / 1ps
interface fwbs_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [62:0] arrival_time;
  logic [15:0] pkt_len;
  modport source(output valid, func, arrival_time, pkt_len, input ready);
  modport sink(input valid, func, arrival_time, pkt_len, output ready);
endinterface

interface fwbs_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  stat_index;
  logic [63:0] stat_value;
  logic        last_stat;
  modport source(output valid, stat_index, stat_value, last_stat, input ready);
  modport sink(input valid, stat_index, stat_value, last_stat, output ready);
endinterface

### design/fwbs_cfg.sv
// Configuration register file with APB-style write and read access.
`timescale 1ns / 1ps
module fwbs_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output fwbs_pkg::cfg_t    cfg
);
  logic        byte_en_r, gap_en_r, burst_en_r;
  logic [31:0] thresh_r, short_r, long_r;
  logic [2:0]  idx;
  logic        wr;

  assign idx = paddr[4:2];
  assign wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_en_r <= 1'b1;
      gap_en_r <= 1'b1;
      burst_en_r <= 1'b1;
      thresh_r <= '0;
      short_r <= '0;
      long_r <= '0;
    end else if (wr) begin
      case (idx)
        fwbs_pkg::REG_BYTE_EN: byte_en_r <= pwdata[0];
        fwbs_pkg::REG_GAP_EN: gap_en_r <= pwdata[0];
        fwbs_pkg::REG_BURST_EN: burst_en_r <= pwdata[0];
        fwbs_pkg::REG_THRESH: thresh_r <= pwdata;
        fwbs_pkg::REG_SHORT: short_r <= pwdata;
        fwbs_pkg::REG_LONG: long_r <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      fwbs_pkg::REG_BYTE_EN: prdata = {31'd0, byte_en_r};
      fwbs_pkg::REG_GAP_EN: prdata = {31'd0, gap_en_r};
      fwbs_pkg::REG_BURST_EN: prdata = {31'd0, burst_en_r};
      fwbs_pkg::REG_THRESH: prdata = thresh_r;
      fwbs_pkg::REG_SHORT: prdata = short_r;
      fwbs_pkg::REG_LONG: prdata = long_r;
      default: prdata = '0;
    endcase
  end

  // Gap limits converted from ms to ns; registered, so no multiplier in the item path.
  logic [51:0] short_ns_r, long_ns_r;
  always_ff @(posedge clk) begin
    short_ns_r <= short_r * fwbs_pkg::NS_PER_MS;
    long_ns_r <= long_r * fwbs_pkg::NS_PER_MS;
  end

  assign cfg.byte_en = byte_en_r;
  assign cfg.gap_en = gap_en_r;
  assign cfg.burst_en = burst_en_r;
  assign cfg.thresh = thresh_r;
  assign cfg.short_ns = short_ns_r;
  assign cfg.long_ns = long_ns_r;
endmodule

### design/fwbs_fifo.sv
// Short request queue between front end and statistics engine.
`timescale 1ns / 1ps
module fwbs_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  fwbs_pkg::req_t   wr_data,
  output logic             full,
  input  logic             rd_en,
  output fwbs_pkg::req_t   rd_data,
  output logic             empty
);
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  fwbs_pkg::req_t mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (rd_en) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end
endmodule

### design/fwbs_engine.sv
// Statistics engine: packet updates, burst detector and the close/emit sequence.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module fwbs_engine (
  input  logic            clk,
  input  logic            rst_n,
  input  fwbs_pkg::cfg_t  cfg,
  input  logic            req_valid,
  input  fwbs_pkg::req_t  req,
  output logic            req_take,
  fwbs_out_if.source      out
);
  typedef enum logic {ST_RUN, ST_EMIT} state_t;
  state_t state_r;
  logic [3:0] idx_r;

  logic [31:0] pkt_cnt_r, byte_sum_r;
  logic [15:0] byte_min_r, byte_max_r;
  logic [63:0] prev_r, gap_sum_r, gap_min_r, gap_max_r;
  logic        gap_seen_r;
  logic [63:0] bbeg_r, blat_r;
  logic [31:0] bbytes_r;
  logic        blive_r, bopen_r;
  logic [31:0] btot_r, bsz_sum_r, bsz_min_r, bsz_max_r;
  logic [63:0] bt_sum_r, bt_min_r, bt_max_r;

  // Snapshot taken at close, drained one statistic per cycle while the sink is free.
  logic [63:0] snap_r [fwbs_pkg::NUM_STATS];

  logic out_free;
  assign out_free = !out.valid || out.ready;
  assign req_take = (state_r == ST_RUN) && req_valid;

  logic [63:0] now, gap, since_lat, since_beg;
  logic [31:0] len32, bsum;
  assign now = {1'b0, req.arrival_time};
  assign len32 = {16'd0, req.pkt_len};
  assign gap = now - prev_r;
  assign since_lat = now - blat_r;
  assign since_beg = now - bbeg_r;
  assign bsum = bbytes_r + len32;

  // Burst being finished (live), values after finish.
  logic [63:0] dur;
  assign dur = blat_r - bbeg_r;
  logic [31:0] f_tot, f_ssum, f_smin, f_smax;
  logic [63:0] f_tsum, f_tmin, f_tmax;
  always_comb begin
    f_tot = btot_r; f_ssum = bsz_sum_r; f_smin = bsz_min_r; f_smax = bsz_max_r;
    f_tsum = bt_sum_r; f_tmin = bt_min_r; f_tmax = bt_max_r;
    if (blive_r) begin
      if (btot_r == '0) begin
        f_tsum = dur; f_tmin = dur; f_tmax = dur;
        f_ssum = bbytes_r; f_smin = bbytes_r; f_smax = bbytes_r;
      end else begin
        f_tsum = bt_sum_r + dur;
        if (dur < bt_min_r) f_tmin = dur;
        else if (dur > bt_max_r) f_tmax = dur;
        f_ssum = bsz_sum_r + bbytes_r;
        if (bbytes_r < bsz_min_r) f_smin = bbytes_r;
        else if (bbytes_r > bsz_max_r) f_smax = bbytes_r;
      end
      f_tot = btot_r + 32'd1;
    end
  end

  logic is_pkt, is_close;
  assign is_pkt = req_take && (req.func == fwbs_pkg::FUNC_PKT);
  assign is_close = req_take && (req.func == fwbs_pkg::FUNC_CLOSE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
      idx_r <= '0;
      out.valid <= 1'b0;
      pkt_cnt_r <= '0; byte_sum_r <= '0; byte_min_r <= '0; byte_max_r <= '0;
      prev_r <= '0; gap_sum_r <= '0; gap_min_r <= '0; gap_max_r <= '0;
      gap_seen_r <= 1'b0;
      bbeg_r <= '0; blat_r <= '0; bbytes_r <= '0; blive_r <= 1'b0; bopen_r <= 1'b0;
      btot_r <= '0; bsz_sum_r <= '0; bsz_min_r <= '0; bsz_max_r <= '0;
      bt_sum_r <= '0; bt_min_r <= '0; bt_max_r <= '0;
    end else begin
      if (out.valid && out.ready && state_r != ST_EMIT) out.valid <= 1'b0;
      case (state_r)
        ST_RUN: begin
          if (is_pkt) begin
            if (cfg.byte_en) begin
              if (pkt_cnt_r == '0) begin
                byte_sum_r <= len32; byte_min_r <= req.pkt_len; byte_max_r <= req.pkt_len;
              end else begin
                byte_sum_r <= byte_sum_r + len32;
                if (req.pkt_len < byte_min_r) byte_min_r <= req.pkt_len;
                else if (req.pkt_len > byte_max_r) byte_max_r <= req.pkt_len;
              end
            end
            if (cfg.gap_en) begin
              if (pkt_cnt_r != '0) begin
                gap_seen_r <= 1'b1;
                if (!gap_seen_r) begin
                  gap_sum_r <= gap; gap_min_r <= gap; gap_max_r <= gap;
                end else begin
                  gap_sum_r <= gap_sum_r + gap;
                  if (gap < gap_min_r) gap_min_r <= gap;
                  else if (gap > gap_max_r) gap_max_r <= gap;
                end
              end
              prev_r <= now;
            end
            if (cfg.burst_en) begin
              if (!bopen_r || (!blive_r && since_beg >= {12'd0, cfg.short_ns})) begin
                bopen_r <= 1'b1; bbeg_r <= now; blat_r <= now; bbytes_r <= len32;
                blive_r <= len32 > cfg.thresh;
              end else if (blive_r && since_lat >= {12'd0, cfg.long_ns}) begin
                btot_r <= f_tot; bsz_sum_r <= f_ssum; bsz_min_r <= f_smin;
                bsz_max_r <= f_smax; bt_sum_r <= f_tsum; bt_min_r <= f_tmin;
                bt_max_r <= f_tmax;
                bopen_r <= 1'b1; bbeg_r <= now; blat_r <= now; bbytes_r <= len32;
                blive_r <= len32 > cfg.thresh;
              end else begin
                bbytes_r <= bsum; blat_r <= now;
                if (!blive_r && bsum > cfg.thresh) blive_r <= 1'b1;
              end
            end
            pkt_cnt_r <= pkt_cnt_r + 32'd1;
          end else if (is_close) begin
            snap_r[0] <= {32'd0, pkt_cnt_r};
            snap_r[1] <= {32'd0, byte_sum_r};
            snap_r[2] <= {48'd0, byte_min_r};
            snap_r[3] <= {48'd0, byte_max_r};
            snap_r[4] <= gap_sum_r;
            snap_r[5] <= gap_min_r;
            snap_r[6] <= gap_max_r;
            if (cfg.burst_en) begin
              snap_r[7] <= {32'd0, f_tot};
              snap_r[8] <= {32'd0, f_ssum};
              snap_r[9] <= {32'd0, f_smin};
              snap_r[10] <= {32'd0, f_smax};
              snap_r[11] <= f_tsum;
              snap_r[12] <= f_tmin;
              snap_r[13] <= f_tmax;
            end else begin
              snap_r[7] <= {32'd0, btot_r};
              snap_r[8] <= {32'd0, bsz_sum_r};
              snap_r[9] <= {32'd0, bsz_min_r};
              snap_r[10] <= {32'd0, bsz_max_r};
              snap_r[11] <= bt_sum_r;
              snap_r[12] <= bt_min_r;
              snap_r[13] <= bt_max_r;
            end
            pkt_cnt_r <= '0; byte_sum_r <= '0; byte_min_r <= '0; byte_max_r <= '0;
            prev_r <= '0; gap_sum_r <= '0; gap_min_r <= '0; gap_max_r <= '0;
            gap_seen_r <= 1'b0;
            bbeg_r <= '0; blat_r <= '0; bbytes_r <= '0; blive_r <= 1'b0; bopen_r <= 1'b0;
            btot_r <= '0; bsz_sum_r <= '0; bsz_min_r <= '0; bsz_max_r <= '0;
            bt_sum_r <= '0; bt_min_r <= '0; bt_max_r <= '0;
            idx_r <= '0;
            state_r <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          // Hold the current result while the sink stalls; load the next one otherwise.
          if (out_free) begin
            out.valid <= 1'b1;
            out.stat_index <= idx_r;
            out.stat_value <= snap_r[idx_r];
            out.last_stat <= (idx_r == fwbs_pkg::LAST_IDX);
            if (idx_r == fwbs_pkg::LAST_IDX) state_r <= ST_RUN;
            else idx_r <= idx_r + 4'd1;
          end
        end
        default: state_r <= ST_RUN;
      endcase
    end
  end

  `CHK_IMPL(a_no_take_emit, clk, rst_n, state_r == ST_EMIT, !req_take, "take during emit")
  `CHK_IMPL(a_last_idx, clk, rst_n, out.valid && out.last_stat, out.stat_index == fwbs_pkg::LAST_IDX, "last")
  `CHK_NEXT(a_close_clears, clk, rst_n, is_close, pkt_cnt_r == '0 && !bopen_r, "close did not clear")
endmodule

### design/flow_window_burst_statistics.sv
// Top level: flow window statistics with burst detection.
`timescale 1ns / 1ps
// Packet request: applied at the edge at which it leaves the queue.
// Close request: snapshotted at the edge at which it leaves the queue; results then pass through
// the output register, one per cycle while the sink is ready.
// Throughput: one packet per cycle outside a close, which holds the engine until 14 results are loaded.
// Reset (rst_n low, synchronous): registers to defaults, all statistics zero, queue empty.
// Gap limits are converted from ms to ns in a register behind the configuration registers.
module flow_window_burst_statistics #(
  parameter int unsigned QDEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  fwbs_in_if.sink     in_ch,
  fwbs_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  fwbs_pkg::cfg_t cfg;
  fwbs_pkg::req_t q_in, q_out;
  logic q_full, q_empty, q_take;

  // Always ready: registers accept writes without wait states.
  assign cfg_pready = 1'b1;

  fwbs_cfg u_cfg (
    .clk, .rst_n, .psel(cfg_psel), .penable(cfg_penable), .pwrite(cfg_pwrite),
    .paddr(cfg_paddr), .pwdata(cfg_pwdata), .prdata(cfg_prdata), .cfg
  );

  // Front end: take requests while the queue has room.
  assign in_ch.ready = !q_full;
  assign q_in.func = in_ch.func;
  assign q_in.arrival_time = in_ch.arrival_time;
  assign q_in.pkt_len = in_ch.pkt_len;

  fwbs_fifo #(.DEPTH(QDEPTH)) u_fifo (
    .clk, .rst_n, .wr_en(in_ch.valid && !q_full), .wr_data(q_in), .full(q_full),
    .rd_en(q_take), .rd_data(q_out), .empty(q_empty)
  );

  // Back end: statistics and result sequencing.
  fwbs_engine u_engine (
    .clk, .rst_n, .cfg, .req_valid(!q_empty), .req(q_out), .req_take(q_take), .out(out_ch)
  );
endmodule
